// File: design/mutf7_pkg.sv
// Shared types and constants of the modified UTF-7 encoder.
package mutf7_pkg;

	localparam int MAX_BYTES = 5;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BYTES);

	localparam logic [6:0] CHAR_AMP  = 7'h26;
	localparam logic [6:0] CHAR_DASH = 7'h2D;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
	} item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_of_run;
		logic       string_done;
	} result_t;

	typedef struct packed {
		logic       in_run;
		logic [3:0] pending_bits;
		logic [2:0] pending_count;
	} enc_state_t;

	// All bytes caused by one input item, in emission order.
	typedef struct packed {
		logic [MAX_BYTES-1:0][6:0] chars;
		logic [CNT_W-1:0]          count;
		logic                      fin;
	} frame_t;

endpackage

// File: design/modified_utf7_encoder.sv
// Top level of the IMAP modified UTF-7 encoder: run state and byte output.
// Each beat in carries one UTF-16 code unit and a flag for the string's last unit; each beat
// out is one ASCII byte, with last_of_run marking the final byte of an item and string_done
// the final byte of the string. An item yields 1 to 5 bytes, handed out one per cycle unless
// result_stall holds the output. A printable unit yields one to four bytes, since closing an
// open run adds a padded character and '-', and an '&' adds its '-'. A unit that is base64
// encoded yields two to five, counting the opening '&' of a run and the close at string end.
// The next item is taken in the same cycle the previous item's last
// byte leaves, so the output byte register is the only limit on throughput.
module modified_utf7_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mutf7_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output mutf7_pkg::result_t  result
);
	import mutf7_pkg::*;

	enc_state_t state_q;
	enc_state_t state_next;
	frame_t     frame;
	logic       busy;
	logic       accept;

	assign item_stall = busy;
	assign accept = item_valid && !busy;

	mutf7_frame u_frame (
		.item    (item),
		.st      (state_q),
		.frame   (frame),
		.st_next (state_next)
	);

	mutf7_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.frame        (frame),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

endmodule

// File: design/mutf7_frame.sv
// Builds the byte list and next encoder state for one code unit.
module mutf7_frame (
	input  mutf7_pkg::item_t      item,
	input  mutf7_pkg::enc_state_t st,
	output mutf7_pkg::frame_t     frame,
	output mutf7_pkg::enc_state_t st_next
);
	import mutf7_pkg::*;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'h2B;
		end else begin
			r = 7'h2C;
		end
		return r;
	endfunction

	// Leftover bits are zero-padded on the right into one character.
	function automatic logic [5:0] pad_group(input logic [3:0] bits, input logic [2:0] cnt);
		logic [5:0] r;
		if (cnt == 3'd2) begin
			r = {bits[1:0], 4'b0000};
		end else begin
			r = {bits[3:0], 2'b00};
		end
		return r;
	endfunction

	logic [CNT_W-1:0] n;
	logic [15:0]      u;
	logic             printable;
	logic [3:0]       rem_bits;
	logic [2:0]       rem_cnt;

	assign u = item.code_unit;
	assign printable = u inside {[16'd32:16'd126]};

	always_comb begin
		n = '0;
		frame.chars = '0;
		st_next = '0;
		rem_bits = '0;
		rem_cnt = '0;
		if (printable) begin
			if (st.in_run) begin
				if (st.pending_count != 3'd0) begin
					frame.chars[n[IDX_W-1:0]] = b64_char(pad_group(st.pending_bits,
						st.pending_count));
					n = n + 1'b1;
				end
				frame.chars[n[IDX_W-1:0]] = CHAR_DASH;
				n = n + 1'b1;
			end
			frame.chars[n[IDX_W-1:0]] = u[6:0];
			n = n + 1'b1;
			if (u[6:0] == CHAR_AMP) begin
				frame.chars[n[IDX_W-1:0]] = CHAR_DASH;
				n = n + 1'b1;
			end
		end else begin
			if (!st.in_run) begin
				frame.chars[n[IDX_W-1:0]] = CHAR_AMP;
				n = n + 1'b1;
			end
			case (st.pending_count)
				3'd2: begin
					frame.chars[n[IDX_W-1:0]] = b64_char({st.pending_bits[1:0], u[15:12]});
					frame.chars[n[IDX_W-1:0] + 1'b1] = b64_char(u[11:6]);
					frame.chars[n[IDX_W-1:0] + 2'd2] = b64_char(u[5:0]);
					n = n + 2'd3;
				end
				3'd4: begin
					frame.chars[n[IDX_W-1:0]] = b64_char({st.pending_bits[3:0], u[15:14]});
					frame.chars[n[IDX_W-1:0] + 1'b1] = b64_char(u[13:8]);
					frame.chars[n[IDX_W-1:0] + 2'd2] = b64_char(u[7:2]);
					n = n + 2'd3;
					rem_bits = {2'b00, u[1:0]};
					rem_cnt = 3'd2;
				end
				default: begin
					frame.chars[n[IDX_W-1:0]] = b64_char(u[15:10]);
					frame.chars[n[IDX_W-1:0] + 1'b1] = b64_char(u[9:4]);
					n = n + 2'd2;
					rem_bits = u[3:0];
					rem_cnt = 3'd4;
				end
			endcase
			st_next.in_run = 1'b1;
			st_next.pending_bits = rem_bits;
			st_next.pending_count = rem_cnt;
			if (item.final_unit) begin
				if (rem_cnt != 3'd0) begin
					frame.chars[n[IDX_W-1:0]] = b64_char(pad_group(rem_bits, rem_cnt));
					n = n + 1'b1;
				end
				frame.chars[n[IDX_W-1:0]] = CHAR_DASH;
				n = n + 1'b1;
				st_next = '0;
			end
		end
		frame.count = n;
		frame.fin = item.final_unit;
	end

endmodule

// File: design/mutf7_serializer.sv
// Holds one item's byte list and hands it out one byte per beat.
module mutf7_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  mutf7_pkg::frame_t    frame,
	output logic                 busy,
	output logic                 result_valid,
	input  logic                 result_stall,
	output mutf7_pkg::result_t   result
);
	import mutf7_pkg::*;

	frame_t           frame_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic             last;
	logic             take;

	assign last = ({1'b0, idx_q} + 1'b1) == {1'b0, frame_q.count};
	assign take = valid_q && !result_stall;
	// A new frame may enter in the cycle the last byte of the old one leaves.
	assign busy = valid_q && !(take && last);

	assign result_valid = valid_q;
	assign result.out_char = frame_q.chars[idx_q];
	assign result.last_of_run = last;
	assign result.string_done = last && frame_q.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

endmodule

// File: verif/tb_modified_utf7_encoder.sv
// Testbench for the modified UTF-7 encoder: directed table, random strings, byte-level checks.
`timescale 1ns / 100ps

module tb_modified_utf7_encoder;
	import mutf7_pkg::*;

	localparam int RANDOM_ITEMS = 355;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		item_t               unit;
		logic [4:0][6:0]     typed;
		logic [2:0]          typed_len;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	enc_state_t enc_state = '0;
	result_t    item_bytes[$];
	result_t    expected_bytes[$];
	dir_row_t   directed_rows[$];
	int         error_count = 0;
	int         cycle_count = 0;
	bit         sender_burst = 1'b0;
	bit         receiver_burst = 1'b0;

	modified_utf7_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Modified base64 alphabet: A-Z, a-z, 0-9, '+', ','.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26)
			c = 7'h41 + 7'(v);
		else if (v < 6'd52)
			c = 7'h61 + 7'(v - 6'd26);
		else if (v < 6'd62)
			c = 7'h30 + 7'(v - 6'd52);
		else if (v == 6'd62)
			c = 7'h2B;
		else
			c = 7'h2C;
		return c;
	endfunction

	function automatic void emit_char(input logic [6:0] c);
		result_t r;
		r.out_char    = c;
		r.last_of_run = 1'b0;
		r.string_done = 1'b0;
		item_bytes.push_back(r);
	endfunction

	function automatic void close_run();
		logic [5:0] pad_val;
		if (enc_state.in_run) begin
			if (enc_state.pending_count != 3'd0) begin
				pad_val = {2'b00, enc_state.pending_bits} << (6 - enc_state.pending_count);
				emit_char(b64_char(pad_val));
			end
			emit_char(CHAR_DASH);
		end
		enc_state = '0;
	endfunction

	// Fills item_bytes with the bytes one code unit produces and advances the run state.
	function automatic void encode_unit(input item_t it);
		logic [19:0] acc;
		int          nbits;
		result_t     tail;
		item_bytes.delete();
		if (it.code_unit >= 16'd32 && it.code_unit < 16'd127) begin
			close_run();
			emit_char(it.code_unit[6:0]);
			if (it.code_unit[6:0] == CHAR_AMP)
				emit_char(CHAR_DASH);
		end else begin
			if (!enc_state.in_run) begin
				emit_char(CHAR_AMP);
				enc_state = '0;
				enc_state.in_run = 1'b1;
			end
			acc = {enc_state.pending_bits, it.code_unit};
			nbits = enc_state.pending_count + 16;
			while (nbits >= 6) begin
				nbits -= 6;
				emit_char(b64_char(6'(acc >> nbits)));
			end
			enc_state.pending_count = 3'(nbits);
			enc_state.pending_bits = 4'(acc & ((20'd1 << nbits) - 20'd1));
			if (it.final_unit)
				close_run();
		end
		tail = item_bytes.pop_back();
		tail.last_of_run = 1'b1;
		tail.string_done = it.final_unit;
		item_bytes.push_back(tail);
	endfunction

	function automatic dir_row_t make_row(input logic [15:0] u, input logic f, input string typed);
		dir_row_t row;
		byte      ch;
		row = '0;
		row.unit.code_unit = u;
		row.unit.final_unit = f;
		row.typed_len = 3'(typed.len());
		for (int i = 0; i < typed.len(); i++) begin
			ch = typed.getc(i);
			row.typed[i] = ch[6:0];
		end
		return row;
	endfunction

	function automatic void check_byte(input result_t got);
		result_t want;
		if (expected_bytes.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("unexpected byte: char %h last %b done %b",
					got.out_char, got.last_of_run, got.string_done);
		end else begin
			want = expected_bytes.pop_front();
			if (got.out_char !== want.out_char || got.last_of_run !== want.last_of_run ||
					got.string_done !== want.string_done) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("byte mismatch: expected char %h last %b done %b, got char %h last %b done %b",
						want.out_char, want.last_of_run, want.string_done,
						got.out_char, got.last_of_run, got.string_done);
			end
		end
	endfunction

	// Presents one code unit and returns at the edge where the beat is taken.
	task automatic send_unit(input item_t it);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_nonprint();
		logic [15:0] u;
		case ($urandom_range(0, 3))
			0: u = 16'($urandom_range(0, 31));
			1: u = 16'h007F;
			2: u = 16'($urandom_range(128, 65535));
			default: u = 16'($urandom_range(0, 65535));
		endcase
		return u;
	endfunction

	initial begin
		int hold;
		forever begin
			if ($urandom_range(0, 63) == 0)
				receiver_burst = !receiver_burst;
			hold = receiver_burst ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (result_valid !== 1'b1) @(posedge clk);
			check_byte(result);
		end
	end

	initial begin
		item_t       it;
		result_t     res;
		logic [15:0] string_units[$];
		int          str_len;
		int          print_pct;
		int          random_sent;

		directed_rows.push_back(make_row(16'h0041, 1'b0, "A"));
		directed_rows.push_back(make_row(16'h0026, 1'b0, "&-"));
		directed_rows.push_back(make_row(16'h0020, 1'b0, " "));
		directed_rows.push_back(make_row(16'h007E, 1'b1, "~"));
		directed_rows.push_back(make_row(16'h0000, 1'b1, "&AAA-"));
		directed_rows.push_back(make_row(16'hFFFF, 1'b1, "&,,8-"));
		directed_rows.push_back(make_row(16'h007F, 1'b1, "&AH8-"));
		directed_rows.push_back(make_row(16'h001F, 1'b1, "&AB8-"));
		directed_rows.push_back(make_row(16'h00E9, 1'b0, ""));
		directed_rows.push_back(make_row(16'h4E2D, 1'b0, ""));
		directed_rows.push_back(make_row(16'hD83D, 1'b0, ""));
		directed_rows.push_back(make_row(16'hDE00, 1'b0, ""));
		directed_rows.push_back(make_row(16'h0078, 1'b0, ""));
		directed_rows.push_back(make_row(16'h8000, 1'b0, ""));
		directed_rows.push_back(make_row(16'h0026, 1'b0, ""));
		directed_rows.push_back(make_row(16'h0001, 1'b0, ""));
		directed_rows.push_back(make_row(16'h0002, 1'b0, ""));
		directed_rows.push_back(make_row(16'h0003, 1'b1, ""));
		directed_rows.push_back(make_row(16'h5555, 1'b0, ""));
		directed_rows.push_back(make_row(16'hAAAA, 1'b1, ""));
		directed_rows.push_back(make_row(16'h0026, 1'b1, ""));
		directed_rows.push_back(make_row(16'h0031, 1'b1, "1"));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			send_unit(directed_rows[r].unit);
			encode_unit(directed_rows[r].unit);
			if (directed_rows[r].typed_len != 3'd0) begin
				for (int i = 0; i < directed_rows[r].typed_len; i++) begin
					res.out_char    = directed_rows[r].typed[i];
					res.last_of_run = (i == directed_rows[r].typed_len - 1);
					res.string_done = res.last_of_run & directed_rows[r].unit.final_unit;
					expected_bytes.push_back(res);
				end
			end else begin
				foreach (item_bytes[i])
					expected_bytes.push_back(item_bytes[i]);
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			string_units.delete();
			print_pct = $urandom_range(0, 100);
			str_len = $urandom_range(1, 12);
			while (string_units.size() < str_len) begin
				if ($urandom_range(0, 99) < print_pct) begin
					if ($urandom_range(0, 7) == 0)
						string_units.push_back(16'h0026);
					else
						string_units.push_back(16'($urandom_range(32, 126)));
				end else if ($urandom_range(0, 4) == 0) begin
					// Surrogate pair: two units inside one run.
					string_units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
					string_units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end else begin
					string_units.push_back(pick_nonprint());
				end
			end
			sender_burst = ($urandom_range(0, 4) == 0);
			// Hold off until the output has drained completely.
			if (random_sent == 0 || $urandom_range(0, 9) == 0) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (expected_bytes.size() != 0) @(posedge clk);
			end
			foreach (string_units[i]) begin
				it.code_unit = string_units[i];
				it.final_unit = (i == string_units.size() - 1);
				send_unit(it);
				encode_unit(it);
				foreach (item_bytes[k])
					expected_bytes.push_back(item_bytes[k]);
				random_sent++;
			end
		end

		item_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
